// ----- sv/tof_pkg.sv -----
// Package: telnet option filter codes, types and sizes.
`timescale 1ns / 1ps
`default_nettype none
package tof_pkg;

  localparam int LineCapacity = 128;
  localparam int CapW         = 13;

  localparam logic [7:0] CodeIac  = 8'd255;
  localparam logic [7:0] CodeDont = 8'd254;
  localparam logic [7:0] CodeDo   = 8'd253;
  localparam logic [7:0] CodeWont = 8'd252;
  localparam logic [7:0] CodeWill = 8'd251;
  localparam logic [7:0] CodeSb   = 8'd250;
  localparam logic [7:0] CodeSe   = 8'd240;
  localparam logic [7:0] CodeCr   = 8'd13;
  localparam logic [7:0] CodeLf   = 8'd10;

  localparam logic [6:0] CountMax = 7'd127;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EOL   = 2'd1,
    KIND_REPLY = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REQ_DATA  = 1'b0,
    REQ_EVENT = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    PH_DATA   = 3'd0,
    PH_IAC    = 3'd1,
    PH_OPT    = 3'd2,
    PH_SB     = 3'd3,
    PH_SB_IAC = 3'd4
  } phase_t;

  // Results caused by one input item: one single result, or a
  // three-byte negotiation reply.
  typedef struct packed {
    logic       reply;
    logic [1:0] kind;
    logic [7:0] data;
    logic [6:0] len;
    logic [7:0] answer;
  } bundle_t;

endpackage
`default_nettype wire

// ----- sv/tof_in_if.sv -----
// Interface: input item channel (request type and received byte).
`timescale 1ns / 1ps
`default_nettype none
interface tof_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface
`default_nettype wire

// ----- sv/tof_out_if.sv -----
// Interface: result item channel.
`timescale 1ns / 1ps
`default_nettype none
interface tof_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [6:0] line_length;
  logic       last;

  modport source (output valid, output out_kind, output out_byte,
                  output line_length, output last, input ready);
  modport sink   (input valid, input out_kind, input out_byte,
                  input line_length, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/tof_parser.sv -----
// Parser: telnet phase state, line counter and per-item result decode.
`timescale 1ns / 1ps
`default_nettype none
module tof_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [0:0]      req_type,
  input  wire logic [7:0]      in_byte,
  output      logic            res_valid,
  output      tof_pkg::bundle_t res
);

  localparam int CapW = tof_pkg::CapW;

  tof_pkg::phase_t phase, phase_next;
  logic [7:0]      pending_command, pending_command_next;
  logic [6:0]      line_count, line_count_next;
  logic            room;

  // Line still has room for one more byte.
  assign room = ((CapW'(line_count) + CapW'(1)) < CapW'(tof_pkg::LineCapacity))
                && (line_count < tof_pkg::CountMax);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tof_pkg::PH_DATA;
      pending_command <= 8'd0;
      line_count      <= 7'd0;
    end else if (accept) begin
      phase           <= phase_next;
      pending_command <= pending_command_next;
      line_count      <= line_count_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    pending_command_next = pending_command;
    line_count_next      = line_count;
    res_valid            = 1'b0;
    res.reply            = 1'b0;
    res.kind             = tof_pkg::KIND_DATA;
    res.data             = in_byte;
    res.len              = 7'd0;
    res.answer           = tof_pkg::CodeWont;

    if (req_type == tof_pkg::REQ_EVENT) begin
      phase_next           = tof_pkg::PH_DATA;
      pending_command_next = 8'd0;
      line_count_next      = 7'd0;
    end else begin
      unique case (phase)
        tof_pkg::PH_IAC: begin
          if (in_byte == tof_pkg::CodeIac) begin
            phase_next = tof_pkg::PH_DATA;
            if (room) begin
              line_count_next = line_count + 7'd1;
              res_valid       = 1'b1;
            end
          end else if (in_byte == tof_pkg::CodeWill || in_byte == tof_pkg::CodeWont ||
                       in_byte == tof_pkg::CodeDo || in_byte == tof_pkg::CodeDont) begin
            pending_command_next = in_byte;
            phase_next           = tof_pkg::PH_OPT;
          end else if (in_byte == tof_pkg::CodeSb) begin
            phase_next = tof_pkg::PH_SB;
          end else begin
            phase_next = tof_pkg::PH_DATA;
          end
        end
        tof_pkg::PH_OPT: begin
          phase_next = tof_pkg::PH_DATA;
          if (pending_command == tof_pkg::CodeDo || pending_command == tof_pkg::CodeWill) begin
            res_valid  = 1'b1;
            res.reply  = 1'b1;
            res.kind   = tof_pkg::KIND_REPLY;
            res.answer = (pending_command == tof_pkg::CodeDo) ? tof_pkg::CodeWont
                                                              : tof_pkg::CodeDont;
          end
        end
        tof_pkg::PH_SB: begin
          if (in_byte == tof_pkg::CodeIac) phase_next = tof_pkg::PH_SB_IAC;
        end
        tof_pkg::PH_SB_IAC: begin
          if (in_byte == tof_pkg::CodeSe) phase_next = tof_pkg::PH_DATA;
          else if (in_byte != tof_pkg::CodeIac) phase_next = tof_pkg::PH_SB;
        end
        default: begin
          phase_next = tof_pkg::PH_DATA;
          if (in_byte == tof_pkg::CodeIac) begin
            phase_next = tof_pkg::PH_IAC;
          end else if (in_byte == tof_pkg::CodeLf) begin
            line_count_next = 7'd0;
            res_valid       = 1'b1;
            res.kind        = tof_pkg::KIND_EOL;
            res.data        = 8'd0;
            res.len         = line_count;
          end else if (in_byte != tof_pkg::CodeCr && room) begin
            line_count_next = line_count + 7'd1;
            res_valid       = 1'b1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/tof_serializer.sv -----
// Serializer: holds one item's results and hands them out one per cycle while the sink is ready.
`timescale 1ns / 1ps
`default_nettype none
module tof_serializer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire tof_pkg::bundle_t res,
  output      logic             take,
  tof_out_if.source             results
);

  logic             bun_valid;
  tof_pkg::bundle_t bun;
  logic [1:0]       idx;
  logic             cur_last;
  logic             fire;

  assign cur_last = !bun.reply || (idx == 2'd2);
  assign fire     = bun_valid && results.ready;
  // Room for a new item's results when empty or the final one leaves now.
  assign take     = !bun_valid || (results.ready && cur_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      bun_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      bun_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (fire) begin
      if (cur_last) bun_valid <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) bun <= res;
  end

  always_comb begin
    results.valid       = bun_valid;
    results.out_kind    = bun.kind;
    results.line_length = bun.len;
    results.last        = cur_last;
    results.out_byte    = bun.data;
    if (bun.reply) begin
      unique case (idx)
        2'd0:    results.out_byte = tof_pkg::CodeIac;
        2'd1:    results.out_byte = bun.answer;
        default: results.out_byte = bun.data;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/telnet_option_filter_core.sv -----
// Top level: telnet option filter, strips IAC sequences and answers negotiation.
// Takes one received byte per item and emits line bytes, end-of-line marks
// with the line length, and refusal replies (IAC WONT x for DO x, IAC DONT x
// for WILL x). A byte is accepted every cycle while each byte gives at most
// one result and the sink is ready; a refused option yields three reply items,
// and the next byte is taken in the cycle the third reply leaves. Bytes that
// give no result (commands, CR, subnegotiation, full line) pass straight
// through the parser, but like any byte they wait while a held result is
// stalled by the sink. A connection event item clears the parser. The first
// result is shown in the cycle after accept, set by the single result register.
`timescale 1ns / 1ps
`default_nettype none
module telnet_option_filter_core (
  input wire logic  clk,
  input wire logic  rst,
  tof_in_if.sink    bytes,
  tof_out_if.source results
);

  logic             take;
  logic             accept;
  logic             res_valid;
  tof_pkg::bundle_t res;

  // Ready does not wait for the result register to drain fully.
  assign bytes.ready = take;
  assign accept      = bytes.valid && take;

  tof_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (bytes.req_type),
    .in_byte   (bytes.in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Only items that cause results occupy the result register.
  tof_serializer u_serializer (
    .clk     (clk),
    .rst     (rst),
    .load    (accept && res_valid),
    .res     (res),
    .take    (take),
    .results (results)
  );

endmodule
`default_nettype wire

// ----- sim/telnet_option_filter_core_test.sv -----
// Testbench: telnet option filter core against its own byte-level predictor.
`timescale 1ns / 1ps
module telnet_option_filter_core_test;
  import tof_pkg::*;

  localparam int HoldAt        = 250;   // items in before the long sink hold-off
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;  // cycles with no item moving on either side
  localparam int SettleCycles  = 8;
  localparam int ItemTarget    = 370;

  // One item toward the block; settle makes the sender wait for the output to drain.
  typedef struct {
    req_t       req;
    logic [7:0] data;
    bit         settle;
  } rx_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [6:0] len;
    logic       fin;
  } owed_t;

  logic clk = 1'b0;
  logic rst;

  tof_in_if  byte_in ();
  tof_out_if result_out ();

  telnet_option_filter_core dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (byte_in),
    .results (result_out)
  );

  always #5 clk = ~clk;

  rx_item_t rx_pending[$];
  owed_t    awaited[$];
  int       queued_items   = 0;
  int       accepted_items = 0;
  int       mismatch_count = 0;
  int       idle_cycles    = 0;
  bit       moved;

  // Predictor state
  phase_t     phase     = PH_DATA;
  logic [7:0] held_cmd  = '0;
  logic [6:0] line_fill = '0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void owe(kind_t k, logic [7:0] d, logic [6:0] n, logic fin);
    owed_t e;
    e.kind = k;
    e.data = d;
    e.len  = n;
    e.fin  = fin;
    awaited.push_back(e);
  endfunction

  // Line keeps at most LineCapacity-1 bytes, and never more than the 7-bit count holds.
  function automatic void take_line_byte(logic [7:0] d);
    if (int'(line_fill) + 1 < LineCapacity && line_fill < CountMax) begin
      line_fill = line_fill + 7'd1;
      owe(KIND_DATA, d, 7'd0, 1'b1);
    end
  endfunction

  function automatic void strip_telnet_byte(req_t req, logic [7:0] b);
    if (req == REQ_EVENT) begin
      // connection opened/closed: parser back to plain data, line emptied
      phase     = PH_DATA;
      held_cmd  = '0;
      line_fill = '0;
    end else begin
      case (phase)
        PH_IAC: begin
          if (b == CodeIac) begin
            phase = PH_DATA;
            take_line_byte(CodeIac);
          end else if (b == CodeWill || b == CodeWont || b == CodeDo || b == CodeDont) begin
            held_cmd = b;
            phase    = PH_OPT;
          end else if (b == CodeSb) begin
            phase = PH_SB;
          end else begin
            phase = PH_DATA;  // any other command is dropped
          end
        end
        PH_OPT: begin
          phase = PH_DATA;
          // DO is refused with WONT, WILL with DONT; WONT/DONT get no answer
          if (held_cmd == CodeDo || held_cmd == CodeWill) begin
            owe(KIND_REPLY, CodeIac, 7'd0, 1'b0);
            owe(KIND_REPLY, (held_cmd == CodeDo) ? CodeWont : CodeDont, 7'd0, 1'b0);
            owe(KIND_REPLY, b, 7'd0, 1'b1);
          end
        end
        PH_SB: begin
          if (b == CodeIac) phase = PH_SB_IAC;
        end
        PH_SB_IAC: begin
          // IAC IAC inside a subnegotiation keeps waiting for SE
          if (b == CodeSe) phase = PH_DATA;
          else if (b != CodeIac) phase = PH_SB;
        end
        default: begin
          phase = PH_DATA;
          if (b == CodeIac) begin
            phase = PH_IAC;
          end else if (b == CodeLf) begin
            owe(KIND_EOL, 8'd0, line_fill, 1'b1);
            line_fill = '0;
          end else if (b != CodeCr) begin
            take_line_byte(b);
          end
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic queue_byte(req_t r, logic [7:0] b, bit settle = 1'b0);
    rx_item_t it;
    it.req    = r;
    it.data   = b;
    it.settle = settle;
    rx_pending.push_back(it);
    queued_items++;
  endtask

  task automatic queue_command(logic [7:0] cmd);
    queue_byte(REQ_DATA, CodeIac);
    queue_byte(REQ_DATA, cmd);
  endtask

  function automatic logic [7:0] pick_negotiation();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = CodeWill;
      1:       c = CodeWont;
      2:       c = CodeDo;
      default: c = CodeDont;
    endcase
    return c;
  endfunction

  // One random sequence: mostly well-formed telnet traffic, some noise and
  // sequences cut short by a connection event.
  task automatic queue_random_chunk();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      queue_byte(REQ_DATA, 8'($urandom_range(0, 254)));
    end else if (pick < 53) begin
      queue_byte(REQ_DATA, CodeLf);
    end else if (pick < 57) begin
      queue_byte(REQ_DATA, CodeCr);
    end else if (pick < 64) begin
      queue_command(CodeIac);
    end else if (pick < 76) begin
      queue_command(pick_negotiation());
      queue_byte(REQ_DATA, 8'($urandom_range(0, 255)));
    end else if (pick < 82) begin
      queue_command(CodeSb);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) queue_command(CodeIac);
        else queue_byte(REQ_DATA, 8'($urandom_range(0, 254)));
      end
      queue_command(CodeSe);
    end else if (pick < 86) begin
      queue_command(8'($urandom_range(0, 249)));  // non-negotiation command
    end else if (pick < 92) begin
      queue_byte(REQ_DATA, 8'($urandom_range(0, 255)));
    end else if (pick < 96) begin
      // broken sequence: connection drops mid-command
      queue_byte(REQ_DATA, CodeIac);
      if ($urandom_range(0, 1) == 1) queue_byte(REQ_DATA, pick_negotiation());
      queue_byte(REQ_EVENT, 8'($urandom_range(0, 255)));
    end else begin
      queue_byte(REQ_EVENT, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0] b;
    bit         mid_settle_done;
    mid_settle_done           = 1'b0;
    rst                       = 1'b1;
    byte_in.valid             = 1'b0;
    byte_in.req_type          = REQ_DATA;
    byte_in.in_byte           = 8'd0;
    result_out.ready          = 1'b0;

    // Directed: extremes, every command, special cases
    queue_byte(REQ_EVENT, 8'hFF);
    queue_byte(REQ_DATA, 8'h00);
    queue_byte(REQ_DATA, 8'hFE);
    queue_byte(REQ_DATA, CodeCr);            // dropped
    queue_byte(REQ_DATA, CodeLf);            // end of line, two bytes
    queue_byte(REQ_DATA, CodeLf);            // empty line
    queue_command(CodeIac);                  // literal 255
    queue_command(CodeDo);
    queue_byte(REQ_DATA, 8'h01);             // refused with WONT
    queue_command(CodeWill);
    queue_byte(REQ_DATA, 8'hFF);             // refused with DONT
    queue_command(CodeWont);
    queue_byte(REQ_DATA, 8'h03);             // no answer
    queue_command(8'hF1);                    // other command, ignored
    queue_command(CodeSb);
    queue_command(CodeIac);                  // escaped IAC inside subnegotiation
    queue_command(8'h05);                    // stray command inside subnegotiation
    queue_command(CodeSe);
    queue_byte(REQ_DATA, CodeLf);

    // Line overflow: run well past capacity, a literal 255 on a full line too
    queue_byte(REQ_DATA, 8'h41, 1'b1);
    for (int i = 0; i < 132; i++) begin
      b = 8'($urandom_range(0, 254));
      if (b == CodeCr || b == CodeLf) b = 8'h41;
      queue_byte(REQ_DATA, b);
    end
    queue_command(CodeIac);
    queue_command(CodeDont);
    queue_byte(REQ_DATA, 8'h00);
    queue_byte(REQ_DATA, CodeLf);

    // Random traffic; once in the middle the sender waits for the output to drain
    while (queued_items < ItemTarget) begin
      if (!mid_settle_done && queued_items > 260) begin
        queue_byte(REQ_DATA, CodeLf, 1'b1);
        mid_settle_done = 1'b1;
      end
      queue_random_chunk();
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (rx_pending.size() != 0 || awaited.size() != 0);
    repeat (SettleCycles) @(negedge clk);

    if (mismatch_count == 0 && awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: bursts of items with random gaps, valid held until taken
  // ---------------------------------------------------------------------------
  int gap_left   = 0;
  int burst_left = 1;
  int shown_id   = -1;

  always @(negedge clk) begin
    if (rst) begin
      byte_in.valid <= 1'b0;
    end else if (byte_in.valid && shown_id == accepted_items) begin
      // current item still waiting for ready
    end else if (gap_left != 0) begin
      gap_left      <= gap_left - 1;
      byte_in.valid <= 1'b0;
    end else if (rx_pending.size() == 0 || (rx_pending[0].settle && awaited.size() != 0)) begin
      byte_in.valid <= 1'b0;
    end else begin
      byte_in.valid    <= 1'b1;
      byte_in.req_type <= rx_pending[0].req;
      byte_in.in_byte  <= rx_pending[0].data;
      shown_id         <= accepted_items;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: rotating stall pattern, one long hold-off so the block backs up
  // ---------------------------------------------------------------------------
  logic [7:0] stall_mask = 8'hFF;
  int         mask_age   = 0;
  int         hold_left  = 0;
  bit         hold_done  = 1'b0;

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left        <= hold_left - 1;
      result_out.ready <= 1'b0;
    end else if (!hold_done && accepted_items >= HoldAt) begin
      hold_done        <= 1'b1;
      hold_left        <= HoldCycles;
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= stall_mask[0];
      if (mask_age == 0) begin
        // a third of the windows run with no stalls at all
        stall_mask <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        mask_age   <= $urandom_range(8, 64);
      end else begin
        stall_mask <= {stall_mask[0], stall_mask[7:1]};
        mask_age   <= mask_age - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results, predict on accepted items, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (result_out.valid && result_out.ready) begin
        moved = 1'b1;
        if (awaited.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, got kind %0d byte %h len %0d last %b", $time,
                   result_out.out_kind, result_out.out_byte, result_out.line_length,
                   result_out.last);
        end else if ({result_out.out_kind, result_out.out_byte, result_out.line_length,
                      result_out.last} !== awaited[0]) begin
          mismatch_count++;
          $display("%0t: result mismatch, expected kind %0d byte %h len %0d last %b, got kind %0d byte %h len %0d last %b",
                   $time, awaited[0].kind, awaited[0].data, awaited[0].len, awaited[0].fin,
                   result_out.out_kind, result_out.out_byte, result_out.line_length,
                   result_out.last);
          void'(awaited.pop_front());
        end else begin
          void'(awaited.pop_front());
        end
      end
      if (byte_in.valid && byte_in.ready) begin
        moved = 1'b1;
        strip_telnet_byte(req_t'(byte_in.req_type), byte_in.in_byte);
        void'(rx_pending.pop_front());
        accepted_items++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
